>>> design/fwh_pkg.sv
`timescale 1ns / 1ps

package fwh_pkg;

	localparam int DW     = 32;
	localparam int BWW    = 31;
	localparam int QW     = 6;
	localparam int LW     = BWW + QW;
	localparam int CFG_IW = 2;

	localparam logic [CFG_IW-1:0] REG_ORIGIN       = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_BIN_WIDTH    = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_MISSING_LAST = CFG_IW'(2);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_RO_START,
		ST_RO_RD,
		ST_RO_EMIT,
		ST_RO_MISS,
		ST_RO_EMPTY
	} state_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic div_step;
		logic mem_rd;
		logic mem_upd;
		logic ro_init;
		logic ro_rd;
		logic ro_next;
		logic emit_bin;
		logic emit_miss;
		logic emit_empty;
		logic clear;
	} fwh_cmd_t;

	typedef struct packed {
		logic missing;
		logic below;
		logic over;
		logic last;
		logic div_last;
		logic any_used;
		logic at_highest;
		logic missing_last;
		logic out_free;
	} fwh_sts_t;

	function automatic logic [DW-1:0] sat_inc(input logic [DW-1:0] v);
		sat_inc = (v == '1) ? v : v + DW'(1);
	endfunction

endpackage

>>> design/fwh_if.sv
`timescale 1ns / 1ps

interface fwh_in_if;
	import fwh_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] sample;
	logic                 is_missing;
	logic                 last;

	modport source (output valid, output sample, output is_missing, output last, input ready);
	modport sink (input valid, input sample, input is_missing, input last, output ready);
endinterface

interface fwh_out_if;
	import fwh_pkg::*;

	logic          valid;
	logic          ready;
	logic          entry_valid;
	logic [QW-1:0] bin_index;
	logic [DW-1:0] bin_count;
	logic          missing_entry;
	logic [DW-1:0] missing_total;
	logic [DW-1:0] dropped_total;
	logic          final_res;

	modport source (
		output valid, output entry_valid, output bin_index, output bin_count,
		output missing_entry, output missing_total, output dropped_total,
		output final_res, input ready
	);
	modport sink (
		input valid, input entry_valid, input bin_index, input bin_count,
		input missing_entry, input missing_total, input dropped_total,
		input final_res, output ready
	);
endinterface

>>> design/fwh_ctrl.sv
`timescale 1ns / 1ps

module fwh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fwh_pkg::fwh_sts_t sts,
	output fwh_pkg::fwh_cmd_t cmd
);
	import fwh_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.classify = 1'b1;
				if (!sts.missing && !sts.below && !sts.over) begin
					state_d = ST_DIV;
				end else if (sts.last) begin
					state_d = ST_RO_START;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.mem_upd = 1'b1;
				state_d     = sts.last ? ST_RO_START : ST_IDLE;
			end
			ST_RO_START: begin
				cmd.ro_init = 1'b1;
				if (sts.any_used) begin
					state_d = ST_RO_RD;
				end else if (sts.missing_last) begin
					state_d = ST_RO_MISS;
				end else begin
					state_d = ST_RO_EMPTY;
				end
			end
			ST_RO_RD: begin
				cmd.ro_rd = 1'b1;
				state_d   = ST_RO_EMIT;
			end
			ST_RO_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_bin = 1'b1;
					if (!sts.at_highest) begin
						cmd.ro_next = 1'b1;
						state_d     = ST_RO_RD;
					end else if (sts.missing_last) begin
						state_d = ST_RO_MISS;
					end else begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_RO_MISS: begin
				if (sts.out_free) begin
					cmd.emit_miss = 1'b1;
					cmd.clear     = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RO_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					cmd.clear      = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/fwh_dpath.sv
`timescale 1ns / 1ps

module fwh_dpath #(
	parameter int NUM_BINS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fwh_pkg::CFG_IW-1:0]           cfg_index,
	input  logic [fwh_pkg::DW-1:0]               cfg_data,
	input  logic signed [fwh_pkg::DW-1:0]        in_sample,
	input  logic                                 in_is_missing,
	input  logic                                 in_last,
	input  fwh_pkg::fwh_cmd_t                    cmd,
	output fwh_pkg::fwh_sts_t                    sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 out_entry_valid,
	output logic [fwh_pkg::QW-1:0]               out_bin_index,
	output logic [fwh_pkg::DW-1:0]               out_bin_count,
	output logic                                 out_missing_entry,
	output logic [fwh_pkg::DW-1:0]               out_missing_total,
	output logic [fwh_pkg::DW-1:0]               out_dropped_total,
	output logic                                 out_final_res
);
	import fwh_pkg::*;

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int SW = $clog2(QW);

	// configuration
	logic signed [DW-1:0] origin_q;
	logic [BWW-1:0]       bin_width_q;
	logic                 missing_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q       <= '0;
			bin_width_q    <= BWW'(65536);
			missing_last_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN:       origin_q       <= cfg_data;
				REG_BIN_WIDTH:    bin_width_q    <= cfg_data[BWW-1:0];
				REG_MISSING_LAST: missing_last_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sample capture
	logic [DW:0]   diff_full;
	logic [DW-1:0] diff_q;
	logic          below_q;
	logic          missing_q;
	logic          last_q;

	assign diff_full = {in_sample[DW-1], in_sample} - {origin_q[DW-1], origin_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q    <= diff_full[DW-1:0];
			below_q   <= diff_full[DW];
			missing_q <= in_is_missing;
			last_q    <= in_last;
		end
	end

	// range check against the full bin span
	logic [LW-1:0] limit;
	logic          over;

	assign limit = LW'(bin_width_q) * LW'(NUM_BINS);
	assign over  = (bin_width_q == '0) || (LW'(diff_q) >= limit);

	// restoring divider, one quotient bit per step
	logic [DW-1:0] rem_q;
	logic [LW-1:0] dsr_q;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic          ge;
	logic [AW-1:0] quo_a;

	assign ge    = LW'(rem_q) >= dsr_q;
	assign quo_a = quo_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			rem_q  <= diff_q;
			dsr_q  <= LW'({bin_width_q, (QW-1)'(0)});
			quo_q  <= '0;
			step_q <= SW'(QW - 1);
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q[DW-1:0];
			end
			dsr_q  <= dsr_q >> 1;
			quo_q  <= {quo_q[QW-2:0], ge};
			step_q <= step_q - SW'(1);
		end
	end

	// counters and bin bookkeeping
	logic [DW-1:0]       missing_cnt_q;
	logic [DW-1:0]       dropped_cnt_q;
	logic [AW-1:0]       highest_q;
	logic                any_used_q;
	logic [NUM_BINS-1:0] bin_vld_q;
	logic [AW-1:0]       ridx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			missing_cnt_q <= '0;
			dropped_cnt_q <= '0;
			highest_q     <= '0;
			any_used_q    <= 1'b0;
			bin_vld_q     <= '0;
		end else if (cmd.clear) begin
			missing_cnt_q <= '0;
			dropped_cnt_q <= '0;
			highest_q     <= '0;
			any_used_q    <= 1'b0;
			bin_vld_q     <= '0;
		end else begin
			if (cmd.classify) begin
				if (missing_q) begin
					missing_cnt_q <= sat_inc(missing_cnt_q);
				end else if (!below_q && over) begin
					dropped_cnt_q <= sat_inc(dropped_cnt_q);
				end
			end
			if (cmd.mem_upd) begin
				bin_vld_q[quo_a] <= 1'b1;
				any_used_q       <= 1'b1;
				if (!any_used_q || (quo_a > highest_q)) begin
					highest_q <= quo_a;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ro_init) begin
			ridx_q <= '0;
		end else if (cmd.ro_next) begin
			ridx_q <= ridx_q + AW'(1);
		end
	end

	// bin store, single read port
	logic [DW-1:0] bin_mem [NUM_BINS];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] cur_cnt;
	logic [DW-1:0] ro_cnt;

	assign rd_addr = cmd.ro_rd ? ridx_q : quo_a;
	assign cur_cnt = bin_vld_q[quo_a] ? rdata_q : '0;
	assign ro_cnt  = bin_vld_q[ridx_q] ? rdata_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.mem_rd || cmd.ro_rd) begin
			rdata_q <= bin_mem[rd_addr];
		end
		if (cmd.mem_upd) begin
			bin_mem[quo_a] <= sat_inc(cur_cnt);
		end
	end

	// output register
	logic out_vld_q;
	logic emit;

	assign emit = cmd.emit_bin || cmd.emit_miss || cmd.emit_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_missing_total <= missing_cnt_q;
			out_dropped_total <= dropped_cnt_q;
			priority if (cmd.emit_bin) begin
				out_entry_valid   <= 1'b1;
				out_bin_index     <= QW'(ridx_q);
				out_bin_count     <= ro_cnt;
				out_missing_entry <= 1'b0;
				out_final_res     <= (ridx_q == highest_q) && !missing_last_q;
			end else if (cmd.emit_miss) begin
				out_entry_valid   <= 1'b1;
				out_bin_index     <= any_used_q ? QW'(highest_q) + QW'(1) : '0;
				out_bin_count     <= missing_cnt_q;
				out_missing_entry <= 1'b1;
				out_final_res     <= 1'b1;
			end else begin
				out_entry_valid   <= 1'b0;
				out_bin_index     <= '0;
				out_bin_count     <= '0;
				out_missing_entry <= 1'b0;
				out_final_res     <= 1'b1;
			end
		end
	end

	assign out_valid = out_vld_q;

	assign sts.missing      = missing_q;
	assign sts.below        = below_q;
	assign sts.over         = over;
	assign sts.last         = last_q;
	assign sts.div_last     = (step_q == '0);
	assign sts.any_used     = any_used_q;
	assign sts.at_highest   = (ridx_q == highest_q);
	assign sts.missing_last = missing_last_q;
	assign sts.out_free     = !out_vld_q || out_ready;

endmodule

>>> design/fixed_width_histogram.sv
`timescale 1ns / 1ps

// channel   dir   payload                                         transfer
// samples   in    sample, is_missing, last                        valid & ready
// results   out   entry_valid, bin_index, bin_count,              valid & ready
//                 missing_entry, missing_total, dropped_total, final_res
//
// a missing, ignored or out-of-range sample ends after the range check; a
// binned sample takes the range check, six restoring divide steps, then bin
// read and write on the single-port bin store. a last sample adds a readout:
// a start step, a read and an emit per reported bin, then the missing entry.
// arst_n clears control, counters and bin valid bits; configuration resets too.
// samples are taken while a finished result still waits in the output register.

module fixed_width_histogram #(
	parameter int NUM_BINS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fwh_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [fwh_pkg::DW-1:0]      cfg_data,
	fwh_in_if.sink                      samples,
	fwh_out_if.source                   results
);
	import fwh_pkg::*;

	fwh_cmd_t cmd;
	fwh_sts_t sts;

	fwh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fwh_dpath #(
		.NUM_BINS (NUM_BINS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_sample         (samples.sample),
		.in_is_missing     (samples.is_missing),
		.in_last           (samples.last),
		.cmd               (cmd),
		.sts               (sts),
		.out_ready         (results.ready),
		.out_valid         (results.valid),
		.out_entry_valid   (results.entry_valid),
		.out_bin_index     (results.bin_index),
		.out_bin_count     (results.bin_count),
		.out_missing_entry (results.missing_entry),
		.out_missing_total (results.missing_total),
		.out_dropped_total (results.dropped_total),
		.out_final_res     (results.final_res)
	);

endmodule

>>> tb/sv/fixed_width_histogram_test.sv
`timescale 1ns / 1ps

module fixed_width_histogram_test;
	import fwh_pkg::*;

	localparam int HIST_BINS = 32;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int ITEM_TARGET = 130;
	localparam int PRINT_LIMIT = 40;
	localparam longint SAMPLE_MIN = -64'sd2147483648;
	localparam longint SAMPLE_MAX = 64'sd2147483647;

	typedef struct packed {
		logic          entry_valid;
		logic [QW-1:0] bin_index;
		logic [DW-1:0] bin_count;
		logic          missing_entry;
		logic [DW-1:0] missing_total;
		logic [DW-1:0] dropped_total;
		logic          final_res;
	} hist_entry_t;

	typedef enum logic [1:0] {
		ROW_REG,
		ROW_ITEM,
		ROW_ITEM_TYPED
	} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CFG_IW-1:0] reg_idx;
		logic [DW-1:0]     value;
		logic              is_missing;
		logic              last;
		hist_entry_t       typed_res;
	} stim_row_t;

	localparam hist_entry_t NO_RES = '0;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [DW-1:0]     cfg_data;

	fwh_in_if  samples_if ();
	fwh_out_if results_if ();

	fixed_width_histogram #(
		.NUM_BINS(HIST_BINS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.samples  (samples_if),
		.results  (results_if)
	);

	logic signed [DW-1:0] cur_origin;
	logic [BWW-1:0]       cur_width;
	logic                 cur_mlast;

	logic [DW-1:0] bin_tally [HIST_BINS];
	int            top_bin;
	bit            any_binned;
	logic [DW-1:0] missing_tally;
	logic [DW-1:0] dropped_tally;

	hist_entry_t readout_q [$];
	hist_entry_t seen;
	hist_entry_t want;

	int fail_count = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	bit steady = 1'b0;
	int run_len;
	int stall_len;

	stim_row_t directed_rows [29] = '{
		'{ROW_ITEM_TYPED, REG_ORIGIN, 32'h8000_0000, 1'b0, 1'b1,
			'{1'b0, 6'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1}},
		'{ROW_ITEM_TYPED, REG_ORIGIN, 32'h7FFF_FFFF, 1'b0, 1'b1,
			'{1'b0, 6'd0, 32'd0, 1'b0, 32'd0, 32'd1, 1'b1}},
		'{ROW_ITEM_TYPED, REG_ORIGIN, 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{1'b0, 6'd0, 32'd0, 1'b0, 32'd1, 32'd0, 1'b1}},
		'{ROW_ITEM, REG_ORIGIN, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h001F_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0001_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0000_8000, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0020_0000, 1'b0, 1'b1, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0003_0000, 1'b0, 1'b1, NO_RES},
		'{ROW_REG, REG_MISSING_LAST, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
		'{ROW_REG, REG_ORIGIN, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_REG, REG_BIN_WIDTH, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h1234_5678, 1'b1, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0000_0000, 1'b0, 1'b1, NO_RES},
		'{ROW_ITEM_TYPED, REG_ORIGIN, 32'h0000_0000, 1'b1, 1'b1,
			'{1'b1, 6'd0, 32'd1, 1'b1, 32'd1, 32'd0, 1'b1}},
		'{ROW_REG, REG_BIN_WIDTH, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_REG, REG_ORIGIN, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_REG, REG_MISSING_LAST, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM_TYPED, REG_ORIGIN, 32'h7FFF_FFFF, 1'b0, 1'b1,
			'{1'b0, 6'd0, 32'd0, 1'b0, 32'd0, 32'd2, 1'b1}},
		'{ROW_REG, REG_ORIGIN, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_REG, REG_BIN_WIDTH, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
		'{ROW_REG, REG_MISSING_LAST, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0000_001E, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{ROW_ITEM, REG_ORIGIN, 32'h0000_0000, 1'b1, 1'b1, NO_RES}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [DW-1:0] bump(input logic [DW-1:0] v);
		return (v == '1) ? v : v + DW'(1);
	endfunction

	function automatic hist_entry_t make_entry(input logic ev, input int idx,
			input logic [DW-1:0] cnt, input logic me, input logic fin);
		return '{ev, QW'(idx), cnt, me, missing_tally, dropped_tally, fin};
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("mismatch: %s", msg);
	endtask

	task automatic add_expected(input hist_entry_t e);
		readout_q.insert(readout_q.size(), e);
	endtask

	task automatic clear_tally();
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		top_bin = 0;
		any_binned = 1'b0;
		missing_tally = '0;
		dropped_tally = '0;
	endtask

	task automatic tally_sample(input logic signed [DW-1:0] value, input logic miss,
			input logic lst);
		longint diff;
		longint bin;
		if (miss) begin
			missing_tally = bump(missing_tally);
		end else if (value >= cur_origin) begin
			diff = longint'(value) - longint'(cur_origin);
			if (cur_width == '0) begin
				dropped_tally = bump(dropped_tally);
			end else begin
				bin = diff / longint'(cur_width);
				if (bin >= HIST_BINS) begin
					dropped_tally = bump(dropped_tally);
				end else begin
					bin_tally[bin] = bump(bin_tally[bin]);
					if (!any_binned || int'(bin) > top_bin)
						top_bin = int'(bin);
					any_binned = 1'b1;
				end
			end
		end
		if (lst) begin
			if (any_binned)
				for (int i = 0; i <= top_bin; i++)
					add_expected(make_entry(1'b1, i, bin_tally[i], 1'b0,
						i == top_bin && !cur_mlast));
			if (cur_mlast)
				add_expected(make_entry(1'b1, any_binned ? top_bin + 1 : 0,
					missing_tally, 1'b1, 1'b1));
			if (!any_binned && !cur_mlast)
				add_expected(make_entry(1'b0, 0, '0, 1'b0, 1'b1));
			clear_tally();
		end
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN: cur_origin = data;
			REG_BIN_WIDTH: cur_width = data[BWW-1:0];
			REG_MISSING_LAST: cur_mlast = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic settle_idle();
		samples_if.valid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_sample(input logic [DW-1:0] value, input logic miss,
			input logic lst);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= value;
		samples_if.is_missing <= miss;
		samples_if.last <= lst;
		do
			@(posedge clk);
		while (!samples_if.ready);
		tally_sample(value, miss, lst);
		items_sent++;
	endtask

	task automatic random_phase();
		logic [DW-1:0] org;
		logic [DW-1:0] wid;
		logic [DW-1:0] value;
		logic          miss;
		int            len;
		int            kind;
		longint        span;
		longint        d;
		longint        v;
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 7))
				0: org = 32'h8000_0000;
				1: org = 32'h7FFF_FFFF;
				2: org = '0;
				3, 4, 5: org = $urandom;
				default: org = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			endcase
			case ($urandom_range(0, 19))
				0: wid = '0;
				1: wid = 32'd1;
				2: wid = 32'h7FFF_FFFF;
				3, 4: wid = $urandom & 32'h7FFF_FFFF;
				default: wid = $urandom_range(1, 32'h0004_0000);
			endcase
			settle_idle();
			write_reg(REG_ORIGIN, org);
			write_reg(REG_BIN_WIDTH, wid);
			write_reg(REG_MISSING_LAST, DW'($urandom_range(0, 1)));
		end
		steady = ($urandom_range(0, 3) == 0);
		len = $urandom_range(1, 12);
		for (int k = 0; k < len; k++) begin
			kind = $urandom_range(0, 19);
			miss = 1'b0;
			if (kind < 2) begin
				miss = 1'b1;
				value = $urandom;
			end else if (kind < 4) begin
				value = $urandom;
			end else if (kind == 4 && longint'(cur_origin) > SAMPLE_MIN) begin
				// somewhere below the lower edge of bin zero
				span = longint'(cur_origin) - SAMPLE_MIN;
				value = DW'(SAMPLE_MIN + longint'($urandom) % span);
			end else begin
				d = longint'($urandom_range(0, HIST_BINS + 2)) * longint'(cur_width);
				if (cur_width != '0)
					d = d + longint'($urandom) % longint'(cur_width);
				v = longint'(cur_origin) + d;
				value = (v > SAMPLE_MAX) ? DW'($urandom) : DW'(v);
			end
			send_sample(value, miss, k == len - 1);
		end
	endtask

	initial begin
		int r;
		run_len = 0;
		results_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
			results_if.ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			r = $urandom_range(0, 99);
			stall_len = (r < 45) ? 0 : (r < 90) ? $urandom_range(1, 3)
				: $urandom_range(4, 30);
			if (stall_len > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			seen = '{results_if.entry_valid, results_if.bin_index, results_if.bin_count,
				results_if.missing_entry, results_if.missing_total,
				results_if.dropped_total, results_if.final_res};
			if (readout_q.size() == 0) begin
				note_mismatch($sformatf("result with nothing expected, bin %0d count %0h",
					seen.bin_index, seen.bin_count));
			end else begin
				want = readout_q.pop_front();
				if (seen.entry_valid !== want.entry_valid)
					note_mismatch($sformatf("bin %0d entry_valid %b, expected %b",
						want.bin_index, seen.entry_valid, want.entry_valid));
				if (seen.bin_index !== want.bin_index)
					note_mismatch($sformatf("bin_index %0d, expected %0d",
						seen.bin_index, want.bin_index));
				if (seen.bin_count !== want.bin_count)
					note_mismatch($sformatf("bin %0d bin_count %0h, expected %0h",
						want.bin_index, seen.bin_count, want.bin_count));
				if (seen.missing_entry !== want.missing_entry)
					note_mismatch($sformatf("bin %0d missing_entry %b, expected %b",
						want.bin_index, seen.missing_entry, want.missing_entry));
				if (seen.missing_total !== want.missing_total)
					note_mismatch($sformatf("bin %0d missing_total %0h, expected %0h",
						want.bin_index, seen.missing_total, want.missing_total));
				if (seen.dropped_total !== want.dropped_total)
					note_mismatch($sformatf("bin %0d dropped_total %0h, expected %0h",
						want.bin_index, seen.dropped_total, want.dropped_total));
				if (seen.final_res !== want.final_res)
					note_mismatch($sformatf("bin %0d final_res %b, expected %b",
						want.bin_index, seen.final_res, want.final_res));
			end
		end
	end

	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ORIGIN;
		cfg_data <= '0;
		samples_if.valid <= 1'b0;
		samples_if.sample <= '0;
		samples_if.is_missing <= 1'b0;
		samples_if.last <= 1'b0;
		cur_origin = '0;
		cur_width = BWW'(65536);
		cur_mlast = 1'b0;
		clear_tally();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_REG: begin
					settle_idle();
					write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
				end
				default: begin
					send_sample(directed_rows[i].value, directed_rows[i].is_missing,
						directed_rows[i].last);
					// readouts with an obvious answer are checked against the typed row
					if (directed_rows[i].kind == ROW_ITEM_TYPED) begin
						void'(readout_q.pop_back());
						add_expected(directed_rows[i].typed_res);
					end
				end
			endcase
		end

		while (items_sent < ITEM_TARGET)
			random_phase();

		settle_idle();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
